// ----- rtl/kfs_pkg.sv -----
// Shared types and constants for the keyframe track sampler.
// No dependencies.
`default_nettype none
package kfs_pkg;

    typedef struct packed {
        logic               action;
        logic        [5:0]  key_index;
        logic        [31:0] key_stamp;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic signed [31:0] query_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic        [1:0]  source;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_FIX,
        ST_CHK,
        ST_FIRST,
        ST_LAST,
        ST_SRCH,
        ST_SCMP,
        ST_LDLO,
        ST_LDHI,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } t_state;

    localparam logic       ACT_WRITE  = 1'b0;
    localparam logic       ACT_SAMPLE = 1'b1;

    localparam logic [1:0] SRC_FALLBACK = 2'd0;
    localparam logic [1:0] SRC_FIRST    = 2'd1;
    localparam logic [1:0] SRC_LAST     = 2'd2;
    localparam logic [1:0] SRC_INTERP   = 2'd3;

    localparam logic [2:0] CFG_KEY_COUNT  = 3'd0;
    localparam logic [2:0] CFG_DURATION   = 3'd1;
    localparam logic [2:0] CFG_FALLBACK_X = 3'd2;
    localparam logic [2:0] CFG_FALLBACK_Y = 3'd3;
    localparam logic [2:0] CFG_FALLBACK_Z = 3'd4;

    localparam logic [31:0] DUR_MIN    = 32'd7;
    localparam int          FRAC_BITS  = 24;
    localparam int          WRAP_STEPS = 32;

endpackage
`default_nettype wire

// ----- rtl/keyframe_track_sampler_core.sv -----
// Keyframe track sampler: key store, time wrap, binary search, linear interpolation.
// Depends on kfs_pkg and kfs_ram.
//
//  channel | valid      | flow control | payload
//  input   | i_in_valid | o_in_stall   | i_in_data  (t_in_item)
//  output  | o_out_valid| i_out_stall  | o_out_data (t_out_item)
//  config  | i_cfg_valid| o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A key write is accepted while idle. An interpolated sample runs 32 remainder steps for the
// time wrap, a fix-up, a check and clamp against the first and last keys, the binary search,
// loads of the two bracketing keys, 24 division steps for the fraction (skipped when their
// stamps are equal), a multiply and accumulate per component through the shared multiplier
// and a hand-off. A clamped sample ends at a key check; a short duration skips wrap and fix-up.
// Reset is synchronous and clears control and configuration; key stores are not cleared.
// The result waits in an output register while the output is stalled.
`default_nettype none
module keyframe_track_sampler_core
    import kfs_pkg::*;
#(
    parameter int KEYS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire t_in_item    i_in_data,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      t_out_item   o_out_data,
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    localparam int AW = $clog2(KEYS);
    localparam int NW = ($clog2(KEYS + 1) > 7) ? $clog2(KEYS + 1) : 7;

    t_state r_state, n_state;

    logic [6:0]  r_key_count;
    logic [31:0] r_dur;
    logic [31:0] r_fb_x, r_fb_y, r_fb_z;

    logic        r_neg, n_neg;
    logic [31:0] r_dvd, n_dvd;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_div, n_div;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_tt, n_tt;
    logic [31:0] r_ta, n_ta;
    logic [31:0] r_tb, n_tb;
    logic [AW-1:0] r_lo, n_lo;
    logic [AW-1:0] r_hi, n_hi;
    logic [AW-1:0] r_mid, n_mid;
    logic [AW-1:0] r_addr, n_addr;
    logic [FRAC_BITS-1:0] r_q, n_q;
    logic [1:0]  r_k, n_k;
    logic [31:0] r_va [3];
    logic [31:0] n_va [3];
    logic [31:0] r_vb [3];
    logic [31:0] n_vb [3];
    logic signed [57:0] r_prod, n_prod;
    t_out_item   r_res, n_res;
    t_out_item   r_out, n_out;
    logic        r_out_valid, n_out_valid;

    logic [NW-1:0] w_n;
    logic [AW-1:0] w_last;
    logic          w_bit;
    logic [33:0]   w_sub;
    logic          w_borrow;
    logic [AW:0]   w_sum;
    logic [AW:0]   w_gap;
    logic signed [32:0] w_delta;
    logic signed [57:0] w_mul;
    logic signed [57:0] w_rnd;
    logic [31:0]   w_lerp;
    logic          w_in_acc;
    logic          w_we;
    logic          w_out_free;
    logic [31:0]   w_s, w_x, w_y, w_z;

    assign w_n = (NW'(r_key_count) > NW'(KEYS)) ? NW'(KEYS) : NW'(r_key_count);
    assign w_last = AW'(w_n - NW'(1));
    assign w_bit = (r_state == ST_WRAP) ? r_dvd[31] : 1'b0;
    assign w_sub = {1'b0, r_rem, w_bit} - {2'b00, r_div};
    assign w_borrow = w_sub[33];
    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_gap = {1'b0, r_hi} - {1'b0, r_lo};
    assign w_delta = $signed({r_vb[r_k][31], r_vb[r_k]}) - $signed({r_va[r_k][31], r_va[r_k]});
    assign w_mul = w_delta * $signed({1'b0, r_q});
    assign w_rnd = r_prod + 58'sd8388608;
    assign w_lerp = r_va[r_k] + 32'(w_rnd >>> FRAC_BITS);
    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_we = w_in_acc && (i_in_data.action == ACT_WRITE)
                  && (32'(i_in_data.key_index) < 32'(KEYS));
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    kfs_ram #(.WIDTH(32), .DEPTH(KEYS)) u_stamp (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(AW'(i_in_data.key_index)),
        .i_wdata(i_in_data.key_stamp), .i_raddr(n_addr), .o_rdata(w_s)
    );
    kfs_ram #(.WIDTH(32), .DEPTH(KEYS)) u_x (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(AW'(i_in_data.key_index)),
        .i_wdata(i_in_data.value_x), .i_raddr(n_addr), .o_rdata(w_x)
    );
    kfs_ram #(.WIDTH(32), .DEPTH(KEYS)) u_y (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(AW'(i_in_data.key_index)),
        .i_wdata(i_in_data.value_y), .i_raddr(n_addr), .o_rdata(w_y)
    );
    kfs_ram #(.WIDTH(32), .DEPTH(KEYS)) u_z (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(AW'(i_in_data.key_index)),
        .i_wdata(i_in_data.value_z), .i_raddr(n_addr), .o_rdata(w_z)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_in_data.action == ACT_SAMPLE) begin
                    n_state = (r_dur < DUR_MIN) ? ST_CHK : ST_WRAP;
                end
            end
            ST_WRAP:  if (r_cnt == 5'(WRAP_STEPS - 1)) n_state = ST_FIX;
            ST_FIX:   n_state = ST_CHK;
            ST_CHK:   n_state = (w_n == '0) ? ST_DONE : ST_FIRST;
            ST_FIRST: n_state = (r_tt <= w_s) ? ST_DONE : ST_LAST;
            ST_LAST:  n_state = (r_tt >= w_s) ? ST_DONE : ST_SRCH;
            ST_SRCH:  n_state = (w_gap > (AW+1)'(1)) ? ST_SCMP : ST_LDLO;
            ST_SCMP:  n_state = ST_SRCH;
            ST_LDLO:  n_state = ST_LDHI;
            ST_LDHI:  n_state = (r_tb == r_ta) ? ST_MUL : ST_DIV;
            ST_DIV:   if (r_cnt == 5'(FRAC_BITS - 1)) n_state = ST_MUL;
            ST_MUL:   n_state = ST_ACC;
            ST_ACC:   n_state = (r_k == 2'd2) ? ST_DONE : ST_MUL;
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_neg = r_neg;
        n_dvd = r_dvd;
        n_rem = r_rem;
        n_div = r_div;
        n_cnt = r_cnt;
        n_tt = r_tt;
        n_ta = r_ta;
        n_tb = r_tb;
        n_lo = r_lo;
        n_hi = r_hi;
        n_mid = r_mid;
        n_addr = r_addr;
        n_q = r_q;
        n_k = r_k;
        n_va = r_va;
        n_vb = r_vb;
        n_prod = r_prod;
        n_res = r_res;
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                n_neg = i_in_data.query_time[31];
                n_dvd = i_in_data.query_time[31] ? 32'(-i_in_data.query_time)
                                                 : i_in_data.query_time;
                n_rem = '0;
                n_div = r_dur;
                n_cnt = '0;
                n_tt = '0;
            end
            ST_WRAP: begin
                n_dvd = {r_dvd[30:0], 1'b0};
                n_rem = w_borrow ? {r_rem[30:0], w_bit} : w_sub[31:0];
                n_cnt = r_cnt + 5'd1;
            end
            ST_FIX: begin
                n_tt = (r_neg && r_rem != '0) ? (r_dur - r_rem) : r_rem;
            end
            ST_CHK: begin
                n_res = '{out_x: r_fb_x, out_y: r_fb_y, out_z: r_fb_z, source: SRC_FALLBACK};
                n_addr = '0;
            end
            ST_FIRST: begin
                n_res = '{out_x: w_x, out_y: w_y, out_z: w_z, source: SRC_FIRST};
                n_ta = w_s;
                n_addr = w_last;
            end
            ST_LAST: begin
                n_res = '{out_x: w_x, out_y: w_y, out_z: w_z, source: SRC_LAST};
                n_tb = w_s;
                n_lo = '0;
                n_hi = w_last;
            end
            ST_SRCH: begin
                n_mid = AW'(w_sum >> 1);
                n_addr = (w_gap > (AW+1)'(1)) ? AW'(w_sum >> 1) : r_lo;
            end
            ST_SCMP: begin
                if (r_tt < w_s) begin
                    n_hi = r_mid;
                    n_tb = w_s;
                end else begin
                    n_lo = r_mid;
                    n_ta = w_s;
                end
            end
            ST_LDLO: begin
                n_va[0] = w_x;
                n_va[1] = w_y;
                n_va[2] = w_z;
                n_addr = r_hi;
            end
            ST_LDHI: begin
                n_vb[0] = w_x;
                n_vb[1] = w_y;
                n_vb[2] = w_z;
                n_rem = r_tt - r_ta;
                n_div = r_tb - r_ta;
                n_cnt = '0;
                n_q = '0;
                n_k = '0;
            end
            ST_DIV: begin
                n_rem = w_borrow ? {r_rem[30:0], 1'b0} : w_sub[31:0];
                n_q = {r_q[FRAC_BITS-2:0], !w_borrow};
                n_cnt = r_cnt + 5'd1;
            end
            ST_MUL: begin
                n_prod = w_mul;
            end
            ST_ACC: begin
                case (r_k)
                    2'd0:    n_res.out_x = w_lerp;
                    2'd1:    n_res.out_y = w_lerp;
                    default: n_res.out_z = w_lerp;
                endcase
                n_res.source = SRC_INTERP;
                n_k = r_k + 2'd1;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_key_count <= '0;
            r_dur <= '0;
            r_fb_x <= '0;
            r_fb_y <= '0;
            r_fb_z <= '0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_KEY_COUNT:  r_key_count <= i_cfg_data[6:0];
                    CFG_DURATION:   r_dur <= i_cfg_data;
                    CFG_FALLBACK_X: r_fb_x <= i_cfg_data;
                    CFG_FALLBACK_Y: r_fb_y <= i_cfg_data;
                    CFG_FALLBACK_Z: r_fb_z <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_div <= n_div;
        r_cnt <= n_cnt;
        r_tt <= n_tt;
        r_ta <= n_ta;
        r_tb <= n_tb;
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_mid <= n_mid;
        r_addr <= n_addr;
        r_q <= n_q;
        r_k <= n_k;
        r_va <= n_va;
        r_vb <= n_vb;
        r_prod <= n_prod;
        r_res <= n_res;
        r_out <= n_out;
    end
endmodule
`default_nettype wire

// ----- rtl/kfs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module kfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
